FILE: rtl/dcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcr_pkg: shared constants for the distance constraint relaxation pipeline
// Holds the fixed field widths, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package dcr_pkg;

    localparam int REST_BITS   = 17;
    localparam int STIFF_BITS  = 9;
    localparam int STATUS_BITS = 2;

    localparam int FRAC_BITS_DEF    = 8;
    localparam int NEWTON_STEPS_DEF = 8;
    localparam int POS_BITS_DEF     = 18;

    localparam logic [STATUS_BITS-1:0] ST_CORRECTED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_SLACK     = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_DROPPED   = 2'd2;

    function automatic int max_i(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage : dcr_pkg
`default_nettype wire

FILE: rtl/dcr_udiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcr_udiv: pipelined unsigned restoring divider
// One quotient bit per register stage, with a sideband that travels along.
// ----------------------------------------------------------------------------
module dcr_udiv
    import dcr_pkg::*;
#(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_n,
    input  wire logic [DW-1:0] in_d,
    input  wire logic [SW-1:0] in_sb,
    output logic               out_valid,
    output logic [NW-1:0]      out_q,
    output logic [SW-1:0]      out_sb
);

    logic          v_reg  [NW];
    logic [DW-1:0] r_reg  [NW];
    logic [NW-1:0] n_reg  [NW];
    logic [NW-1:0] q_reg  [NW];
    logic [DW-1:0] d_reg  [NW];
    logic [SW-1:0] sb_reg [NW];

    logic          v_in  [NW];
    logic [DW-1:0] r_in  [NW];
    logic [NW-1:0] n_in  [NW];
    logic [NW-1:0] q_in  [NW];
    logic [DW-1:0] d_in  [NW];
    logic [SW-1:0] sb_in [NW];

    logic [DW-1:0] r_next [NW];
    logic [NW-1:0] q_next [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign v_in[s]  = in_valid;
            assign r_in[s]  = '0;
            assign n_in[s]  = in_n;
            assign q_in[s]  = '0;
            assign d_in[s]  = in_d;
            assign sb_in[s] = in_sb;
        end else begin : g_rest
            assign v_in[s]  = v_reg[s-1];
            assign r_in[s]  = r_reg[s-1];
            assign n_in[s]  = n_reg[s-1];
            assign q_in[s]  = q_reg[s-1];
            assign d_in[s]  = d_reg[s-1];
            assign sb_in[s] = sb_reg[s-1];
        end

        always_comb begin
            logic [DW:0] r2;
            logic [DW:0] diff;
            logic        ge;
            r2   = {r_in[s], n_in[s][NW-1-s]};
            diff = r2 - {1'b0, d_in[s]};
            ge   = (r2 >= {1'b0, d_in[s]});
            r_next[s] = ge ? diff[DW-1:0] : r2[DW-1:0];
            q_next[s] = q_in[s];
            q_next[s][NW-1-s] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_in[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[s]  <= r_next[s];
                q_reg[s]  <= q_next[s];
                n_reg[s]  <= n_in[s];
                d_reg[s]  <= d_in[s];
                sb_reg[s] <= sb_in[s];
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign out_q     = q_reg[NW-1];
    assign out_sb    = sb_reg[NW-1];

endmodule : dcr_udiv
`default_nettype wire

FILE: rtl/dcr_newton.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcr_newton: one pipelined Newton step of the fixed-point square root
// Divides the scaled radicand by the guess, then averages and checks repeat.
// ----------------------------------------------------------------------------
module dcr_newton
    import dcr_pkg::*;
#(
    parameter int NUMW = 16,
    parameter int GW   = 8,
    parameter int SW   = 1
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [NUMW-1:0] in_num,
    input  wire logic [GW-1:0]   in_g,
    input  wire logic            in_done,
    input  wire logic [SW-1:0]   in_sb,
    output logic                 out_valid,
    output logic [NUMW-1:0]      out_num,
    output logic [GW-1:0]        out_g,
    output logic                 out_done,
    output logic [SW-1:0]        out_sb
);

    localparam int DSW = NUMW + GW + 1 + SW;

    logic            dv;
    logic [NUMW-1:0] dq;
    logic [DSW-1:0]  dsb;
    logic [NUMW-1:0] d_num;
    logic [GW-1:0]   d_g;
    logic            d_done;
    logic [SW-1:0]   d_sb;

    dcr_udiv #(
        .NW (NUMW),
        .DW (GW),
        .SW (DSW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid),
        .in_n      (in_num),
        .in_d      (in_g),
        .in_sb     ({in_num, in_g, in_done, in_sb}),
        .out_valid (dv),
        .out_q     (dq),
        .out_sb    (dsb)
    );

    assign {d_num, d_g, d_done, d_sb} = dsb;

    logic            valid_reg;
    logic [NUMW-1:0] num_reg;
    logic [GW-1:0]   g_reg;
    logic [GW-1:0]   g_next;
    logic            done_reg;
    logic            done_next;
    logic [SW-1:0]   sb_reg;

    always_comb begin
        logic [NUMW:0] sum;
        logic [GW-1:0] gn;
        sum = {1'b0, dq} + (NUMW+1)'(d_g);
        gn  = sum[GW:1];
        if (d_done) begin
            g_next    = d_g;
            done_next = 1'b1;
        end else begin
            g_next    = gn;
            done_next = (gn == d_g);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= dv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg  <= d_num;
            g_reg    <= g_next;
            done_reg <= done_next;
            sb_reg   <= d_sb;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_g     = g_reg;
    assign out_done  = done_reg;
    assign out_sb    = sb_reg;

endmodule : dcr_newton
`default_nettype wire

FILE: rtl/distance_constraint_relax.sv
`default_nettype none
// The Newton dividers make up most of the pipeline from input beat to result beat.
// Throughput: one constraint per cycle; every stage is a register, a stall on
// the result side freezes the whole pipeline for that cycle.
// Reset: synchronous active-low aresetn clears every stage valid bit; data
// registers are not reset.
// ----------------------------------------------------------------------------
// distance_constraint_relax: pipelined position-based distance constraint
// Computes the distance with an unrolled Newton square root, divides the
// length error by it, scales by stiffness and moves the unpinned endpoints.
// ----------------------------------------------------------------------------
module distance_constraint_relax
    import dcr_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int NEWTON_STEPS = NEWTON_STEPS_DEF,
    parameter int POS_BITS     = POS_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [POS_BITS-1:0]  s_a_x,
    input  wire logic signed [POS_BITS-1:0]  s_a_y,
    input  wire logic signed [POS_BITS-1:0]  s_b_x,
    input  wire logic signed [POS_BITS-1:0]  s_b_y,
    input  wire logic [REST_BITS-1:0]        s_rest_len,
    input  wire logic [STIFF_BITS-1:0]       s_stiff,
    input  wire logic                        s_elastic,
    input  wire logic                        s_a_pinned,
    input  wire logic                        s_b_pinned,
    input  wire logic                        s_a_live,
    input  wire logic                        s_b_live,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [POS_BITS-1:0]       m_new_a_x,
    output logic signed [POS_BITS-1:0]       m_new_a_y,
    output logic signed [POS_BITS-1:0]       m_new_b_x,
    output logic signed [POS_BITS-1:0]       m_new_b_y,
    output logic [STATUS_BITS-1:0]           m_status
);

    // Width plan. The squared distance D2 never overflows; the guess must also
    // hold the fixed-point one. The final quotient magnitude is bounded by
    // the rest length over the smallest nonzero root, which is 2^(F/2).
    localparam int DXW  = POS_BITS + 1;
    localparam int SQW  = 2 * DXW;
    localparam int D2W  = SQW - FRAC_BITS + 1;
    localparam int GW   = max_i(D2W, FRAC_BITS + 1);
    localparam int NUMW = D2W + FRAC_BITS;
    localparam int MW   = max_i(REST_BITS, GW);
    localparam int FNW  = MW + FRAC_BITS;
    localparam int QMW  = REST_BITS + FRAC_BITS - FRAC_BITS / 2 + 1;
    localparam int QSW  = QMW + 1;
    localparam int PRW  = QSW + STIFF_BITS + 1;
    localparam int CRW  = PRW - FRAC_BITS;
    localparam int PXW  = DXW + CRW;
    localparam int SUMW = PXW + 1;

    localparam logic [GW-1:0] FIX_ONE = GW'(1) << FRAC_BITS;
    localparam logic signed [SUMW-1:0] POS_HI = (SUMW'(1) <<< (POS_BITS - 1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] POS_LO = -POS_HI - SUMW'(1);

    typedef struct packed {
        logic signed [POS_BITS-1:0] ax;
        logic signed [POS_BITS-1:0] ay;
        logic signed [POS_BITS-1:0] bx;
        logic signed [POS_BITS-1:0] by;
        logic [REST_BITS-1:0]       rest;
        logic [STIFF_BITS-1:0]      stiff;
        logic                       elastic;
        logic                       apin;
        logic                       bpin;
        logic                       live;
        logic signed [DXW-1:0]      dx;
        logic signed [DXW-1:0]      dy;
    } item_t;

    typedef struct packed {
        item_t it;
        logic  slack;
        logic  neg;
    } fin_t;

    localparam int IW = $bits(item_t);
    localparam int FW = $bits(fin_t);

    // One enable for the whole pipeline: it moves whenever the output
    // register is empty or its beat is being taken.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Stage 1: register the item together with the coordinate differences.
    logic  v1_reg;
    item_t it1_reg;
    item_t it1_next;

    always_comb begin
        it1_next.ax      = s_a_x;
        it1_next.ay      = s_a_y;
        it1_next.bx      = s_b_x;
        it1_next.by      = s_b_y;
        it1_next.rest    = s_rest_len;
        it1_next.stiff   = s_stiff;
        it1_next.elastic = s_elastic;
        it1_next.apin    = s_a_pinned;
        it1_next.bpin    = s_b_pinned;
        it1_next.live    = s_a_live && s_b_live;
        it1_next.dx      = DXW'(s_b_x) - DXW'(s_a_x);
        it1_next.dy      = DXW'(s_b_y) - DXW'(s_a_y);
    end

    // Stage 2: the two squares, one multiplier each.
    logic          v2_reg;
    item_t         it2_reg;
    logic [SQW-1:0] sqx_reg;
    logic [SQW-1:0] sqy_reg;

    // Stage 3: squared distance, Newton radicand and start guess. A zero
    // radicand is marked finished with guess zero, which later reads as one.
    logic            v3_reg;
    item_t           it3_reg;
    logic [NUMW-1:0] num3_reg;
    logic [GW-1:0]   g3_reg;
    logic            done3_reg;
    logic [D2W-1:0]  d2_next;
    logic [GW-1:0]   g3_next;

    always_comb begin
        d2_next = D2W'(sqx_reg >> FRAC_BITS) + D2W'(sqy_reg >> FRAC_BITS);
        if (d2_next == '0) begin
            g3_next = '0;
        end else if (GW'(d2_next) < FIX_ONE) begin
            g3_next = FIX_ONE;
        end else begin
            g3_next = GW'(d2_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it1_reg   <= it1_next;
            it2_reg   <= it1_reg;
            sqx_reg   <= SQW'(it1_reg.dx) * SQW'(it1_reg.dx);
            sqy_reg   <= SQW'(it1_reg.dy) * SQW'(it1_reg.dy);
            it3_reg   <= it2_reg;
            num3_reg  <= NUMW'(d2_next) << FRAC_BITS;
            g3_reg    <= g3_next;
            done3_reg <= (d2_next == '0);
        end
    end

    // Newton square root: one divider pipeline and update stage per step.
    // A finished guess rides through the remaining steps unchanged.
    logic            nv    [NEWTON_STEPS+1];
    logic [NUMW-1:0] nnum  [NEWTON_STEPS+1];
    logic [GW-1:0]   ng    [NEWTON_STEPS+1];
    logic            ndone [NEWTON_STEPS+1];
    logic [IW-1:0]   nsb   [NEWTON_STEPS+1];

    assign nv[0]    = v3_reg;
    assign nnum[0]  = num3_reg;
    assign ng[0]    = g3_reg;
    assign ndone[0] = done3_reg;
    assign nsb[0]   = IW'(it3_reg);

    for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_newton
        dcr_newton #(
            .NUMW (NUMW),
            .GW   (GW),
            .SW   (IW)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (nv[k]),
            .in_num    (nnum[k]),
            .in_g      (ng[k]),
            .in_done   (ndone[k]),
            .in_sb     (nsb[k]),
            .out_valid (nv[k+1]),
            .out_num   (nnum[k+1]),
            .out_g     (ng[k+1]),
            .out_done  (ndone[k+1]),
            .out_sb    (nsb[k+1])
        );
    end

    // Stage 4: distance, elastic slack test and length error magnitude.
    item_t          itn;
    logic [MW-1:0]  dist_ext;
    logic [MW-1:0]  rest_ext;
    logic [GW-1:0]  dist_next;

    assign itn       = item_t'(nsb[NEWTON_STEPS]);
    assign dist_next = (ng[NEWTON_STEPS] == '0) ? FIX_ONE : ng[NEWTON_STEPS];
    assign dist_ext  = MW'(dist_next);
    assign rest_ext  = MW'(itn.rest);

    logic           v4_reg;
    fin_t           f4_reg;
    logic [FNW-1:0] fnum4_reg;
    logic [GW-1:0]  dist4_reg;
    fin_t           f4_next;
    logic [MW-1:0]  mag_next;

    always_comb begin
        f4_next.it    = itn;
        f4_next.neg   = (dist_ext > rest_ext);
        f4_next.slack = itn.elastic && (dist_ext <= rest_ext);
        mag_next      = f4_next.neg ? (dist_ext - rest_ext) : (rest_ext - dist_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= nv[NEWTON_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f4_reg    <= f4_next;
            fnum4_reg <= FNW'(mag_next) << FRAC_BITS;
            dist4_reg <= dist_next;
        end
    end

    // Correction quotient: magnitude divided by distance, truncating, so the
    // sign is put back afterwards to round toward zero.
    logic           dv5;
    logic [FNW-1:0] dq5;
    logic [FW-1:0]  dsb5;

    dcr_udiv #(
        .NW (FNW),
        .DW (GW),
        .SW (FW)
    ) u_corr_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_n      (fnum4_reg),
        .in_d      (dist4_reg),
        .in_sb     (FW'(f4_reg)),
        .out_valid (dv5),
        .out_q     (dq5),
        .out_sb    (dsb5)
    );

    // Stage 5: signed quotient. Stage 6: times stiffness. Stage 7: scale
    // back, flooring. The correction stays far inside its saturation bound
    // for every legal parameter set, so no clamp is built.
    fin_t f5d;
    assign f5d = fin_t'(dsb5);

    logic                   v5_reg, v6_reg, v7_reg, v8_reg;
    fin_t                   f5_reg, f6_reg, f7_reg, f8_reg;
    logic signed [QSW-1:0]  q5_reg;
    logic signed [QSW-1:0]  q5_next;
    logic signed [PRW-1:0]  prod6_reg;
    logic signed [CRW-1:0]  corr7_reg;
    logic signed [PXW-1:0]  px8_reg;
    logic signed [PXW-1:0]  py8_reg;

    always_comb begin
        q5_next = $signed({1'b0, dq5[QMW-1:0]});
        if (f5d.neg) begin
            q5_next = -q5_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= dv5;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f5_reg    <= f5d;
            q5_reg    <= q5_next;
            f6_reg    <= f5_reg;
            prod6_reg <= PRW'(q5_reg) * PRW'($signed({1'b0, f5_reg.it.stiff}));
            f7_reg    <= f6_reg;
            corr7_reg <= CRW'(prod6_reg >>> FRAC_BITS);
            f8_reg    <= f7_reg;
            px8_reg   <= PXW'(f7_reg.it.dx) * PXW'(corr7_reg);
            py8_reg   <= PXW'(f7_reg.it.dy) * PXW'(corr7_reg);
        end
    end

    // Output stage: half the product moves each free endpoint, then the
    // positions saturate. Dropped and slack constraints echo the inputs.
    function automatic logic signed [POS_BITS-1:0] sat_pos(
        input logic signed [SUMW-1:0] v
    );
        logic signed [POS_BITS-1:0] r;
        if (v > POS_HI) begin
            r = POS_HI[POS_BITS-1:0];
        end else if (v < POS_LO) begin
            r = POS_LO[POS_BITS-1:0];
        end else begin
            r = v[POS_BITS-1:0];
        end
        return r;
    endfunction

    logic signed [SUMW-1:0]     cx, cy;
    logic signed [POS_BITS-1:0] nax_next, nay_next, nbx_next, nby_next;
    logic [STATUS_BITS-1:0]     status_next;

    assign cx = SUMW'(px8_reg >>> (FRAC_BITS + 1));
    assign cy = SUMW'(py8_reg >>> (FRAC_BITS + 1));

    always_comb begin
        nax_next    = f8_reg.it.ax;
        nay_next    = f8_reg.it.ay;
        nbx_next    = f8_reg.it.bx;
        nby_next    = f8_reg.it.by;
        status_next = ST_CORRECTED;
        if (!f8_reg.it.live) begin
            status_next = ST_DROPPED;
        end else if (f8_reg.slack) begin
            status_next = ST_SLACK;
        end else begin
            if (!f8_reg.it.apin) begin
                nax_next = sat_pos(SUMW'(f8_reg.it.ax) - cx);
                nay_next = sat_pos(SUMW'(f8_reg.it.ay) - cy);
            end
            if (!f8_reg.it.bpin) begin
                nbx_next = sat_pos(SUMW'(f8_reg.it.bx) + cx);
                nby_next = sat_pos(SUMW'(f8_reg.it.by) + cy);
            end
        end
    end

    logic                       m_valid_reg;
    logic signed [POS_BITS-1:0] nax_reg, nay_reg, nbx_reg, nby_reg;
    logic [STATUS_BITS-1:0]     status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nax_reg    <= nax_next;
            nay_reg    <= nay_next;
            nbx_reg    <= nbx_next;
            nby_reg    <= nby_next;
            status_reg <= status_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_new_a_x = nax_reg;
    assign m_new_a_y = nay_reg;
    assign m_new_b_x = nbx_reg;
    assign m_new_b_y = nby_reg;
    assign m_status  = status_reg;

endmodule : distance_constraint_relax
`default_nettype wire
